// ===== design/sle_pkg.sv =====
// Package of shared types, codes and constants for the sorted list engine.
`default_nettype none
package sle_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic do_ins;
        logic do_del;
    } t_cell_cmd;

endpackage
`default_nettype wire

// ===== design/sle_cell.sv =====
// One storage cell of the sorted chain: holds an entry and shifts with its neighbours.
`default_nettype none
module sle_cell (
    input  wire logic               i_clk,
    input  wire sle_pkg::t_cell_cmd i_cmd,
    input  wire logic signed [31:0] i_key,
    input  wire logic               i_used,
    input  wire logic               i_prev_ins,
    input  wire logic signed [31:0] i_prev_val,
    input  wire logic signed [31:0] i_next_val,
    output logic signed [31:0]      o_val,
    output logic                    o_ins,
    output logic                    o_eq,
    output logic                    o_ge
);

    logic signed [31:0] r_val;
    logic signed [31:0] n_val;

    assign o_val = r_val;
    assign o_ins = !i_used || (i_key < r_val);
    assign o_eq  = i_used && (r_val == i_key);
    assign o_ge  = i_used && (r_val >= i_key);

    always_comb begin
        n_val = r_val;
        if (i_cmd.do_ins && o_ins) begin
            n_val = i_prev_ins ? i_prev_val : i_key;
        end else if (i_cmd.do_del && o_ge) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
`default_nettype wire

// ===== design/sorted_list_engine.sv =====
// Top level of the sorted list engine: a chain of cells with count and result register.
// The registered result beat appears in the cycle after the input beat is accepted.
// Throughput: one item per cycle while no result beat is held back, as every cell
// compares the key in parallel and shifts its entry to a neighbour in the same cycle.
// Reset clears the entry count and the result valid flag; cell contents are not
// reset and no clearing pass is needed.
`default_nettype none
module sorted_list_engine #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [31:0] i_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_status,
    output logic [4:0]              o_position,
    output logic [4:0]              o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic [1:0]          r_status;
    logic [1:0]          n_status;
    logic [4:0]          r_position;
    logic [4:0]          n_position;
    logic [4:0]          r_entry_count;
    logic [31:0]         count_wide;

    logic                accept;
    logic                full;
    logic                found;
    sle_pkg::t_cell_cmd  cmd;

    logic signed [31:0]  vals [CAPACITY];
    logic [CAPACITY-1:0] used;
    logic [CAPACITY-1:0] ins;
    logic [CAPACITY-1:0] eq;
    logic [CAPACITY-1:0] ge;
    logic [CAPACITY-1:0] first;
    logic [4:0]          pos_terms [CAPACITY];
    logic [4:0]          match_pos;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (32'(r_count) >= 32'(CAPACITY));
    assign found      = |first;

    assign cmd.do_ins = accept && (i_op == sle_pkg::OP_INSERT) && !full;
    assign cmd.do_del = accept && (i_op == sle_pkg::OP_DELETE) && found;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign used[g] = (32'(g) < 32'(r_count));

        if (g == 0) begin : g_head
            assign first[g] = eq[g];
        end else begin : g_body
            assign first[g] = eq[g] && !eq[g-1];
        end

        assign pos_terms[g] = first[g] ? 5'(g + 1) : 5'd0;

        sle_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_key      (i_value),
            .i_used     (used[g]),
            .i_prev_ins ((g == 0) ? 1'b0 : ins[(g == 0) ? 0 : g - 1]),
            .i_prev_val (vals[(g == 0) ? 0 : g - 1]),
            .i_next_val (vals[(g == CAPACITY - 1) ? g : g + 1]),
            .o_val      (vals[g]),
            .o_ins      (ins[g]),
            .o_eq       (eq[g]),
            .o_ge       (ge[g])
        );
    end

    always_comb begin
        match_pos = 5'd0;
        for (int k = 0; k < CAPACITY; k++) begin
            match_pos = match_pos | pos_terms[k];
        end
    end

    always_comb begin
        n_count    = r_count;
        n_status   = sle_pkg::ST_OK;
        n_position = 5'd0;
        unique case (i_op)
            sle_pkg::OP_INSERT: begin
                if (full) begin
                    n_status = sle_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            sle_pkg::OP_DELETE: begin
                if (r_count == '0) begin
                    n_status = sle_pkg::ST_EMPTY;
                end else if (!found) begin
                    n_status = sle_pkg::ST_ABSENT;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            sle_pkg::OP_SEARCH: begin
                if (!found) begin
                    n_status = sle_pkg::ST_ABSENT;
                end else begin
                    n_position = match_pos;
                end
            end
            default: begin
                n_status = sle_pkg::ST_OK;
            end
        endcase
    end

    assign count_wide = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= n_status;
            r_position    <= n_position;
            r_entry_count <= count_wide[4:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_entry_count = r_entry_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_first_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(first))
        else $error("more than one first match in the chain");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.do_ins |=> (32'(r_count) == 32'($past(r_count)) + 32'd1))
        else $error("insert did not grow the list");

    a_empty_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == sle_pkg::OP_DELETE) && (r_count == '0))
        |=> (o_status == sle_pkg::ST_EMPTY))
        else $error("delete on empty list not flagged");

    a_no_dual_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.do_ins && cmd.do_del))
        else $error("insert and delete shift at once");

    a_first_in_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (first & ~ge) == '0)
        else $error("first match lies outside the shifting part of the chain");

endmodule
`default_nettype wire

// ===== tb/sorted_list_engine_test.sv =====
// Self-checking testbench for the sorted list engine, with a list predictor and result scoreboard.
module sorted_list_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = sle_pkg::CAPACITY_DEFAULT;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam int RANDOM_ITEMS = 930;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] position;
        logic [4:0] entry_count;
    } t_list_result;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_op_mix;

    class t_list_scoreboard;
        logic signed [31:0] held[$];
        t_list_result due[$];
        int errors = 0;
        int checked = 0;

        function int find_equal(logic signed [31:0] v);
            foreach (held[i])
                if (held[i] == v)
                    return i;
            return -1;
        endfunction

        function void note_input(logic [1:0] op, logic signed [31:0] v);
            t_list_result r;
            int i;
            r.status = sle_pkg::ST_OK;
            r.position = '0;
            case (op)
                sle_pkg::OP_INSERT: begin
                    if (held.size() >= CAPACITY) begin
                        r.status = sle_pkg::ST_FULL;
                    end else begin
                        i = 0;
                        while (i < held.size() && held[i] <= v)
                            i++;
                        held.insert(i, v);
                    end
                end
                sle_pkg::OP_DELETE: begin
                    if (held.size() == 0) begin
                        r.status = sle_pkg::ST_EMPTY;
                    end else begin
                        i = find_equal(v);
                        if (i < 0)
                            r.status = sle_pkg::ST_ABSENT;
                        else
                            held.delete(i);
                    end
                end
                sle_pkg::OP_SEARCH: begin
                    i = find_equal(v);
                    if (i < 0)
                        r.status = sle_pkg::ST_ABSENT;
                    else
                        r.position = 5'(i + 1);
                end
                default: begin
                end
            endcase
            r.entry_count = 5'(held.size());
            due.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [4:0] position,
                                   logic [4:0] entry_count);
            t_list_result e;
            checked++;
            if (due.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
                return;
            end
            e = due.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                errors++;
            end
            if (position !== e.position) begin
                $error("position: expected %0d, actual %0d", e.position, position);
                errors++;
            end
            if (entry_count !== e.entry_count) begin
                $error("entry_count: expected %0d, actual %0d", e.entry_count, entry_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [1:0] i_op = sle_pkg::OP_INSERT;
    logic signed [31:0] i_value = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    logic [1:0] o_status;
    logic [4:0] o_position;
    logic [4:0] o_entry_count;

    t_list_scoreboard sb = new();

    int burst_left = 0;
    int rx_cycle = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int cycle_count = 0;

    sorted_list_engine #(.CAPACITY(CAPACITY)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_item(input logic [1:0] op, input logic signed [31:0] v);
        i_in_valid <= 1'b1;
        i_op <= op;
        i_value <= v;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_input(op, v);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_drained();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        int k;
        r = $urandom_range(0, 9);
        if (r < 4 && sb.held.size() != 0)
            return sb.held[$urandom_range(0, sb.held.size() - 1)];
        if (r < 7) begin
            k = $urandom_range(0, 8);
            return k - 4;
        end
        if (r == 7) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_MIN + 1;
                default: return VAL_MAX - 1;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [1:0] pick_op(t_op_mix mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return OP_UNUSED;
        case (mix)
            MIX_FILL: return (r < 80) ? sle_pkg::OP_INSERT
                           : (r < 90) ? sle_pkg::OP_DELETE : sle_pkg::OP_SEARCH;
            MIX_DRAIN: return (r < 20) ? sle_pkg::OP_INSERT
                            : (r < 85) ? sle_pkg::OP_DELETE : sle_pkg::OP_SEARCH;
            default: return (r < 40) ? sle_pkg::OP_INSERT
                          : (r < 70) ? sle_pkg::OP_DELETE : sle_pkg::OP_SEARCH;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_position, o_entry_count);
        rx_cycle++;
        if (!hold_done && sb.checked >= 300) begin
            hold_done = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 97) % 3)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 1) == 0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sorted_list_engine: mismatch");
        $finish;
    end

    initial begin
        t_op_mix mix;
        logic [1:0] op;
        mix = MIX_BALANCED;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(sle_pkg::OP_DELETE, 32'sd5);
        send_item(sle_pkg::OP_SEARCH, 32'sd0);
        send_item(OP_UNUSED, 32'sd7);
        send_item(sle_pkg::OP_INSERT, VAL_MAX);
        send_item(sle_pkg::OP_INSERT, VAL_MIN);
        send_item(sle_pkg::OP_INSERT, -32'sd1);
        send_item(sle_pkg::OP_INSERT, 32'sd0);
        send_item(sle_pkg::OP_INSERT, -32'sd1);
        send_item(sle_pkg::OP_INSERT, 32'sh5555_5555);
        send_item(sle_pkg::OP_INSERT, 32'shAAAA_AAAA);
        send_item(sle_pkg::OP_SEARCH, -32'sd1);
        send_item(sle_pkg::OP_SEARCH, VAL_MAX);
        send_item(sle_pkg::OP_SEARCH, VAL_MIN);
        send_item(sle_pkg::OP_SEARCH, 32'sd3);
        send_item(sle_pkg::OP_DELETE, 32'sd3);
        send_item(sle_pkg::OP_DELETE, -32'sd1);
        send_item(OP_UNUSED, -32'sd1);
        send_item(sle_pkg::OP_DELETE, VAL_MIN);
        send_item(sle_pkg::OP_DELETE, VAL_MAX);
        send_item(sle_pkg::OP_SEARCH, VAL_MIN);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                mix = t_op_mix'($urandom_range(0, 2));
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            op = pick_op(mix);
            send_item(op, pick_value());
            pace_sender();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("sorted_list_engine: match");
        else
            $display("sorted_list_engine: mismatch");
        $finish;
    end
endmodule
